>>> design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and codes for the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int ADDR_W     = 32;
   localparam int PAGE_SHIFT = 12;
   localparam int FRAME_W    = ADDR_W - PAGE_SHIFT;
   localparam int STATUS_W   = 3;
   localparam int FCOUNT_W   = 13;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NO_FRAME = 3'd1,
      ST_IGN_OFF  = 3'd2,
      ST_IGN_RSV  = 3'd3,
      ST_ABSORBED = 3'd4,
      ST_DROPPED  = 3'd5
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_END = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGING_ON  = 8'd1;

   // stack operation for one accepted word
   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctl_type;

endpackage

>>> design/pfa_if.sv
// ----------------------------------------------------------------------------
// pfa_if
// Valid/ready channels of the page frame allocator.
// ----------------------------------------------------------------------------
interface pfa_req_if
   import pfa_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [ADDR_W-1:0] frame_addr;

   modport source (output valid, operation, frame_addr, input ready);
   modport sink   (input valid, operation, frame_addr, output ready);
endinterface

interface pfa_rsp_if
   import pfa_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   alloc_addr;
   logic [STATUS_W-1:0] status;
   logic [FCOUNT_W-1:0] free_count;

   modport source (output valid, alloc_addr, status, free_count, input ready);
   modport sink   (input valid, alloc_addr, status, free_count, output ready);
endinterface

interface pfa_csr_if
   import pfa_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/pfa_stack.sv
// ----------------------------------------------------------------------------
// pfa_stack
// Free-frame stack: top and next entries cached in flops, the rest in a
// memory with registered read, so push or pop can run every cycle.
// ----------------------------------------------------------------------------
module pfa_stack
   import pfa_pkg::*;
#(
   parameter int DEPTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  stk_ctl_type                ctl,
   input  logic [FRAME_W-1:0]         push_frame,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic [FRAME_W-1:0]         top_frame
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int AW    = $clog2(DEPTH);

   logic [FRAME_W-1:0] mem [DEPTH];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [FRAME_W-1:0] tos_ff, tos_in;
   logic [FRAME_W-1:0] nos_ff, nos_in;
   logic [FRAME_W-1:0] rd_ff;
   logic               nos_mem_ff, nos_mem_in;
   logic [FRAME_W-1:0] nos_eff;
   logic [CNT_W-1:0]   wr_ptr, rd_ptr;

   // entry below top is either cached or just read back after a pop
   assign nos_eff = nos_mem_ff ? rd_ff : nos_ff;
   assign wr_ptr  = count_ff - CNT_W'(1);
   assign rd_ptr  = count_ff - CNT_W'(3);

   always_comb begin
      count_in   = count_ff;
      tos_in     = tos_ff;
      nos_in     = nos_eff;
      nos_mem_in = 1'b0;
      if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
         tos_in   = push_frame;
         nos_in   = tos_ff;
      end else if (ctl.pop) begin
         count_in   = count_ff - CNT_W'(1);
         tos_in     = nos_eff;
         nos_mem_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         nos_mem_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         nos_mem_ff <= nos_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      nos_ff <= nos_in;
   end

   // old top goes down into the memory on a push
   always_ff @(posedge clock) begin
      if (ctl.push && count_ff != '0) begin
         mem[wr_ptr[AW-1:0]] <= tos_ff;
      end
   end

   // prefetch the entry two below the top on a pop
   always_ff @(posedge clock) begin
      if (ctl.pop && count_ff >= CNT_W'(3)) begin
         rd_ff <= mem[rd_ptr[AW-1:0]];
      end
   end

   assign count     = count_ff;
   assign top_frame = tos_ff;

endmodule

>>> design/page_frame_allocator.sv
// A result word is registered at the end of the cycle in which its request is taken.
// Throughput: one request per cycle while results are not stalled; the stack top
// and the entry below it are held in flops and the stack memory is read one pop ahead.
// Reset: counters, capacity, bump pointer and mode clear; stack contents are
// left undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// page_frame_allocator
// Hands out and takes back 4 KiB frames by bump pointer or free stack.
// ----------------------------------------------------------------------------
module page_frame_allocator
   import pfa_pkg::*;
#(
   parameter int STACK_DEPTH    = 4096,
   parameter int GROWTH_ENTRIES = 1024
) (
   input logic       clock,
   input logic       reset,
   pfa_req_if.sink   req_bus,
   pfa_rsp_if.source rsp_bus,
   pfa_csr_if.sink   csr_bus
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int GRW_W  = $clog2(GROWTH_ENTRIES + 1);
   localparam int CAP_W  = ((CNT_W > GRW_W) ? CNT_W : GRW_W) + 1;
   localparam int EXT_W  = (CNT_W > FCOUNT_W) ? CNT_W : FCOUNT_W;

   logic [FRAME_W-1:0]  page_ff, page_in;
   logic [FRAME_W-1:0]  bump_ff, bump_in;
   logic                paging_ff, paging_in;
   logic [CNT_W-1:0]    cap_ff, cap_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   status_type          status_ff, status_in;
   logic [FCOUNT_W-1:0] fcount_ff, fcount_in;

   logic                accept;
   logic                csr_we;
   stk_ctl_type         stk_ctl;
   logic [CNT_W-1:0]    stk_count;
   logic [FRAME_W-1:0]  stk_top;
   logic [CNT_W-1:0]    count_after;
   logic [EXT_W-1:0]    count_ext;
   logic                reserved;
   logic                full;
   logic                can_grow;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   // a register word waits while a request word is being taken
   assign csr_bus.ready = !accept;
   assign csr_we        = csr_bus.valid && csr_bus.ready;

   // page_ff is the page number of the used end; a free at or below it is reserved
   assign reserved = req_bus.frame_addr[ADDR_W-1:PAGE_SHIFT] <= page_ff;
   assign full     = stk_count >= cap_ff;
   assign can_grow = (CAP_W'(cap_ff) + CAP_W'(GROWTH_ENTRIES)) <= CAP_W'(STACK_DEPTH);

   always_comb begin
      stk_ctl   = '0;
      addr_in   = '0;
      status_in = ST_OK;
      bump_in   = bump_ff;
      page_in   = page_ff;
      cap_in    = cap_ff;
      paging_in = paging_ff;
      if (accept) begin
         if (op_type'(req_bus.operation) == OP_ALLOC) begin
            if (!paging_ff) begin
               addr_in = {page_ff, PAGE_SHIFT'(0)};
               bump_in = bump_ff + FRAME_W'(1);
               page_in = page_ff + FRAME_W'(1);
            end else if (stk_count == '0) begin
               status_in = ST_NO_FRAME;
            end else begin
               stk_ctl.pop = 1'b1;
               addr_in     = {stk_top, PAGE_SHIFT'(0)};
            end
         end else begin
            if (!paging_ff) begin
               status_in = ST_IGN_OFF;
            end else if (reserved) begin
               status_in = ST_IGN_RSV;
            end else if (full) begin
               if (can_grow) begin
                  cap_in    = cap_ff + CNT_W'(GROWTH_ENTRIES);
                  status_in = ST_ABSORBED;
               end else begin
                  status_in = ST_DROPPED;
               end
            end else begin
               stk_ctl.push = 1'b1;
            end
         end
      end else if (csr_we) begin
         unique case (csr_bus.index)
            CSR_KERNEL_END: page_in = csr_bus.data[ADDR_W-1:PAGE_SHIFT] + FRAME_W'(1)
                                      + bump_ff;
            CSR_PAGING_ON:  paging_in = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      count_after = stk_count;
      if (stk_ctl.push) begin
         count_after = stk_count + CNT_W'(1);
      end else if (stk_ctl.pop) begin
         count_after = stk_count - CNT_W'(1);
      end
      count_ext    = EXT_W'(count_after);
      fcount_in    = count_ext[FCOUNT_W-1:0];
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);
   end

   pfa_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .ctl        (stk_ctl),
      .push_frame (req_bus.frame_addr[ADDR_W-1:PAGE_SHIFT]),
      .count      (stk_count),
      .top_frame  (stk_top)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff      <= FRAME_W'(1);
         bump_ff      <= '0;
         paging_ff    <= 1'b0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         page_ff      <= page_in;
         bump_ff      <= bump_in;
         paging_ff    <= paging_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= addr_in;
         status_ff <= status_in;
         fcount_ff <= fcount_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.alloc_addr = addr_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.free_count = fcount_ff;

endmodule

>>> design/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks on the allocator's result channel.
// ----------------------------------------------------------------------------
module pfa_checker
   import pfa_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [ADDR_W-1:0]   alloc_addr,
   input logic [STATUS_W-1:0] status,
   input logic [FCOUNT_W-1:0] free_count
);

   // a stalled word keeps its valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a stalled word keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(alloc_addr) && $stable(status)
         && $stable(free_count))
      else $error("result word changed while stalled");

   // a taken request always yields a word next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no result word");

   // no frame handed out unless the status is ok; out of frames means empty
   a_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_OK |-> alloc_addr == '0
         && (status != ST_NO_FRAME || free_count == '0))
      else $error("frame address or count wrong for status");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .alloc_addr (rsp_bus.alloc_addr),
   .status     (rsp_bus.status),
   .free_count (rsp_bus.free_count)
);
